FILE: rtl/mrt_pkg.sv
// Shared types and constants for the masked route table.
// No dependencies; imported by every module of the block.
`default_nettype none
package mrt_pkg;

	// Table depth, newest entry in cell 0
	localparam int TABLE_ENTRIES = 16;
	// Levels of the parallel prefix used for the first-match pick
	localparam int PRIO_LEVELS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_ADD          = 3'd0,
		OP_DELETE       = 3'd1,
		OP_ATTACH       = 3'd2,
		OP_DETACH       = 3'd3,
		OP_CLEAR_SELECT = 3'd4,
		OP_LOOKUP       = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOMATCH = 2'd2
	} status_t;

	// One command transaction as it travels down the pipeline
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] seg;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [31:0] sel;
		logic [31:0] addr;
	} cmd_t;

	// One route entry, as held in a cell and passed to its neighbors
	typedef struct packed {
		logic        valid;
		logic        mp;
		logic [31:0] seg;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [31:0] sel;
	} entry_t;

	// Per-cell update controls from the pick logic
	typedef struct packed {
		logic upd;        // second stage holds a command
		logic full;       // last cell is valid
		logic any_exact;  // some cell holds an exact match
		logic first;      // this cell is the first exact match
		logic after;      // this cell is at or behind the first exact match
	} cell_ctl_t;

	// Per-cell compare results, registered for the second stage
	typedef struct packed {
		logic exact;
		logic lookup;
	} cell_hit_t;

endpackage
`default_nettype wire

FILE: rtl/mrt_prio.sv
// First-match pick over the cell hit vector: inclusive prefix OR and one-hot first.
// Depends on mrt_pkg (TABLE_ENTRIES, PRIO_LEVELS).
`default_nettype none
module mrt_prio (
	input  wire logic [mrt_pkg::TABLE_ENTRIES-1:0] hits,
	output logic      [mrt_pkg::TABLE_ENTRIES-1:0] at_or_after,
	output logic      [mrt_pkg::TABLE_ENTRIES-1:0] first
);
	import mrt_pkg::*;

	logic [TABLE_ENTRIES-1:0] lvl [PRIO_LEVELS+1];

	// Log-depth prefix OR, low index has priority
	always_comb begin
		lvl[0] = hits;
		for (int l = 0; l < PRIO_LEVELS; l++) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (i >= (1 << l)) begin
					lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
				end else begin
					lvl[l+1][i] = lvl[l][i];
				end
			end
		end
	end

	assign at_or_after = lvl[PRIO_LEVELS];

	// First hit: set in the prefix, not set one place ahead
	always_comb begin
		first[0] = at_or_after[0];
		for (int i = 1; i < TABLE_ENTRIES; i++) begin
			first[i] = at_or_after[i] & ~at_or_after[i-1];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mrt_cell.sv
// One route table cell: holds an entry, compares it against the command,
// and shifts to or from its neighbors on add and delete.
// Depends on mrt_pkg (cmd_t, entry_t, cell_ctl_t, cell_hit_t, op_t).
`default_nettype none
module mrt_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mrt_pkg::cmd_t      cmd_s1,
	input  wire mrt_pkg::cmd_t      cmd_s2,
	input  wire mrt_pkg::cell_ctl_t ctl,
	input  wire mrt_pkg::entry_t    left_ent,
	input  wire mrt_pkg::entry_t    right_ent,
	output mrt_pkg::entry_t         ent,
	output mrt_pkg::cell_hit_t      hit_s2
);
	import mrt_pkg::*;

	logic        valid_q, mp_q;
	logic [31:0] seg_q, mask_q, hop_q, sel_q;
	entry_t      nxt;
	logic        ld_ctl, ld_data;

	assign ent = '{valid: valid_q, mp: mp_q, seg: seg_q, mask: mask_q,
		hop: hop_q, sel: sel_q};

	// Stage one compares, registered for the pick
	always_ff @(posedge clk) begin
		hit_s2.exact  <= valid_q && (seg_q == cmd_s1.seg) && (mask_q == cmd_s1.mask);
		hit_s2.lookup <= valid_q && ((cmd_s1.addr & mask_q) == seg_q);
	end

	// Stage two update decision
	always_comb begin
		nxt     = ent;
		ld_ctl  = 1'b0;
		ld_data = 1'b0;
		if (ctl.upd) begin
			case (op_t'(cmd_s2.op))
				OP_ADD: begin
					if (!ctl.full) begin
						nxt     = left_ent;
						ld_ctl  = 1'b1;
						ld_data = 1'b1;
					end
				end
				OP_DELETE: begin
					if (ctl.any_exact && ctl.after) begin
						nxt     = right_ent;
						ld_ctl  = 1'b1;
						ld_data = 1'b1;
					end
				end
				OP_ATTACH: begin
					if (ctl.first) begin
						nxt.mp  = 1'b1;
						nxt.sel = cmd_s2.sel;
						ld_ctl  = 1'b1;
						ld_data = 1'b1;
					end
				end
				OP_DETACH: begin
					if (ctl.first) begin
						nxt.mp  = 1'b0;
						nxt.sel = '0;
						ld_ctl  = 1'b1;
						ld_data = 1'b1;
					end
				end
				OP_CLEAR_SELECT: begin
					if (valid_q && mp_q && (sel_q == cmd_s2.sel)) begin
						nxt.mp = 1'b0;
						ld_ctl = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Valid and multipath flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mp_q    <= 1'b0;
		end else if (ld_ctl) begin
			valid_q <= nxt.valid;
			mp_q    <= nxt.mp;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (ld_data) begin
			seg_q  <= nxt.seg;
			mask_q <= nxt.mask;
			hop_q  <= nxt.hop;
			sel_q  <= nxt.sel;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/masked_route_table_top.sv
// Done strobes with the result, both registered at the end of the pick stage after
// the compare stage. A new transaction is accepted only once the last has left the
// compare stage: busy covers it, and cell updates land at the end of the pick stage,
// before the next compare. Every cell compares in parallel; a log-depth prefix picks
// the first match. Reset clears all valid and multipath flags; the receiver cannot stall.
// Depends on mrt_pkg, mrt_cell, mrt_prio.
`default_nettype none
module masked_route_table_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [31:0] route_seg,
	input  wire logic [31:0] seg_mask,
	input  wire logic [31:0] hop_addr,
	input  wire logic [31:0] selector_addr,
	input  wire logic [31:0] lookup_addr,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      hop_out,
	output logic             multipath_out,
	output logic [31:0]      selector_out
);
	import mrt_pkg::*;

	logic      v_s1, v_s2;
	cmd_t      cmd_s1, cmd_s2;
	entry_t    ents [TABLE_ENTRIES];
	cell_hit_t hits [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] exact_vec, lookup_vec;
	logic [TABLE_ENTRIES-1:0] exact_after, exact_first, lookup_after, lookup_first;
	logic      full, any_exact, any_lookup;
	entry_t    pick;
	status_t   st_nxt;
	logic [31:0] hop_nxt, sel_nxt;
	logic        mp_nxt;
	logic        done_q, mp_q;
	logic [1:0]  status_q;
	logic [31:0] hop_q, sel_q;

	assign busy = v_s1;

	// Command pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// Command payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= '{op: opcode, seg: route_seg, mask: seg_mask, hop: hop_addr,
				sel: selector_addr, addr: lookup_addr};
		end
		cmd_s2 <= cmd_s1;
	end

	// Chain of cells
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		entry_t    left_e, right_e;
		cell_ctl_t ctl;

		if (g == 0) begin : g_head
			assign left_e = '{valid: 1'b1, mp: 1'b0, seg: cmd_s2.seg, mask: cmd_s2.mask,
				hop: cmd_s2.hop, sel: '0};
		end else begin : g_mid
			assign left_e = ents[g-1];
		end
		if (g == TABLE_ENTRIES - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = ents[g+1];
		end

		assign ctl = '{upd: v_s2, full: full, any_exact: any_exact,
			first: exact_first[g], after: exact_after[g]};

		mrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd_s1    (cmd_s1),
			.cmd_s2    (cmd_s2),
			.ctl       (ctl),
			.left_ent  (left_e),
			.right_ent (right_e),
			.ent       (ents[g]),
			.hit_s2    (hits[g])
		);

		assign exact_vec[g]  = hits[g].exact;
		assign lookup_vec[g] = hits[g].lookup;
	end

	assign full = ents[TABLE_ENTRIES-1].valid;

	// First-match picks for exact and lookup hits
	mrt_prio u_prio_exact (
		.hits        (exact_vec),
		.at_or_after (exact_after),
		.first       (exact_first)
	);

	mrt_prio u_prio_lookup (
		.hits        (lookup_vec),
		.at_or_after (lookup_after),
		.first       (lookup_first)
	);

	assign any_exact  = exact_after[TABLE_ENTRIES-1];
	assign any_lookup = lookup_after[TABLE_ENTRIES-1];

	// One-hot select of the matched entry
	always_comb begin
		pick = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			pick = pick | (ents[i] & {$bits(entry_t){lookup_first[i]}});
		end
	end

	// Result formation
	always_comb begin
		st_nxt  = ST_DONE;
		hop_nxt = '0;
		mp_nxt  = 1'b0;
		sel_nxt = '0;
		case (op_t'(cmd_s2.op))
			OP_ADD: begin
				if (full) st_nxt = ST_FULL;
			end
			OP_DELETE, OP_ATTACH, OP_DETACH: begin
				if (!any_exact) st_nxt = ST_NOMATCH;
			end
			OP_LOOKUP: begin
				if (any_lookup) begin
					hop_nxt = pick.hop;
					mp_nxt  = pick.mp;
					sel_nxt = pick.mp ? pick.sel : '0;
				end else begin
					st_nxt  = ST_NOMATCH;
					hop_nxt = BROADCAST_ADDR;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (v_s2) begin
			status_q <= st_nxt;
			hop_q    <= hop_nxt;
			mp_q     <= mp_nxt;
			sel_q    <= sel_nxt;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign hop_out       = hop_q;
	assign multipath_out = mp_q;
	assign selector_out  = sel_q;

endmodule
`default_nettype wire

FILE: dv/mrt_tb_pkg.sv
// Scoreboard for the masked route table testbench: a table predictor and reply checker.
// Depends on mrt_pkg for the table depth, opcodes, status codes and entry layout.
package mrt_tb_pkg;
	import mrt_pkg::*;

	// Expected reply of one transaction
	typedef struct {
		status_t     st;
		logic [31:0] hop;
		logic        mp;
		logic [31:0] sel;
	} route_reply_t;

	class route_table_checker;
		entry_t       routes[TABLE_ENTRIES];
		route_reply_t expected_replies[$];
		int unsigned  mismatches = 0;

		function new();
			for (int i = 0; i < TABLE_ENTRIES; i++)
				routes[i] = '0;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		// Apply one accepted command to the table copy and queue its reply
		function void note_command(logic [2:0] op, logic [31:0] seg, logic [31:0] mask,
				logic [31:0] hop, logic [31:0] sel, logic [31:0] addr);
			route_reply_t r;
			int exact;
			int first_hit;
			r.st = ST_DONE;
			r.hop = '0;
			r.mp = 1'b0;
			r.sel = '0;
			// newest exact segment/mask match, shared by delete/attach/detach
			exact = -1;
			for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
				if (routes[i].valid && routes[i].seg == seg && routes[i].mask == mask)
					exact = i;
			case (op)
				OP_ADD: begin
					if (routes[TABLE_ENTRIES - 1].valid) begin
						r.st = ST_FULL;
					end else begin
						for (int i = TABLE_ENTRIES - 1; i > 0; i--)
							routes[i] = routes[i - 1];
						routes[0] = '0;
						routes[0].valid = 1'b1;
						routes[0].seg = seg;
						routes[0].mask = mask;
						routes[0].hop = hop;
					end
				end
				OP_DELETE: begin
					if (exact < 0) begin
						r.st = ST_NOMATCH;
					end else begin
						for (int i = exact; i < TABLE_ENTRIES - 1; i++)
							routes[i] = routes[i + 1];
						routes[TABLE_ENTRIES - 1] = '0;
					end
				end
				OP_ATTACH: begin
					if (exact < 0) begin
						r.st = ST_NOMATCH;
					end else begin
						routes[exact].mp = 1'b1;
						routes[exact].sel = sel;
					end
				end
				OP_DETACH: begin
					if (exact < 0) begin
						r.st = ST_NOMATCH;
					end else begin
						routes[exact].mp = 1'b0;
						routes[exact].sel = '0;
					end
				end
				OP_CLEAR_SELECT: begin
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (routes[i].valid && routes[i].mp && routes[i].sel == sel)
							routes[i].mp = 1'b0;
				end
				OP_LOOKUP: begin
					first_hit = -1;
					for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
						if (routes[i].valid && (addr & routes[i].mask) == routes[i].seg)
							first_hit = i;
					if (first_hit < 0) begin
						r.st = ST_NOMATCH;
						r.hop = BROADCAST_ADDR;
					end else begin
						r.hop = routes[first_hit].hop;
						r.mp = routes[first_hit].mp;
						r.sel = routes[first_hit].mp ? routes[first_hit].sel : '0;
					end
				end
				default: ;  // unused opcodes leave the table alone
			endcase
			expected_replies.push_back(r);
		endfunction

		// Compare one strobed result with the oldest expected reply
		function void check_reply(logic [1:0] st, logic [31:0] hop, logic mp, logic [31:0] sel);
			route_reply_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d hop %h mp %0d sel %h",
					$time, st, hop, mp, sel);
				mismatches++;
				return;
			end
			want = expected_replies.pop_front();
			if (st !== want.st) begin
				$display("%0t: status mismatch: expected %0d, actual %0d", $time, want.st, st);
				mismatches++;
			end
			if (hop !== want.hop) begin
				$display("%0t: hop_out mismatch: expected %h, actual %h", $time, want.hop, hop);
				mismatches++;
			end
			if (mp !== want.mp) begin
				$display("%0t: multipath_out mismatch: expected %0d, actual %0d", $time, want.mp, mp);
				mismatches++;
			end
			if (sel !== want.sel) begin
				$display("%0t: selector_out mismatch: expected %h, actual %h", $time, want.sel, sel);
				mismatches++;
			end
		endfunction
	endclass

endpackage

FILE: dv/tb_masked_route_table_top.sv
// Testbench top for masked_route_table_top: directed and random route commands.
// Depends on mrt_pkg and mrt_tb_pkg; results are checked by route_table_checker.
module tb_masked_route_table_top;
	import mrt_pkg::*;
	import mrt_tb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  opcode = '0;
	logic [31:0] route_seg = '0;
	logic [31:0] seg_mask = '0;
	logic [31:0] hop_addr = '0;
	logic [31:0] selector_addr = '0;
	logic [31:0] lookup_addr = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [31:0] hop_out;
	logic        multipath_out;
	logic [31:0] selector_out;

	// Small pools so that random commands hit existing routes
	logic [31:0] pool_seg[8];
	logic [31:0] pool_mask[8];
	logic [31:0] sel_pool[4];

	route_table_checker sb = new();

	masked_route_table_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.route_seg(route_seg),
		.seg_mask(seg_mask),
		.hop_addr(hop_addr),
		.selector_addr(selector_addr),
		.lookup_addr(lookup_addr),
		.done(done),
		.status(status),
		.hop_out(hop_out),
		.multipath_out(multipath_out),
		.selector_out(selector_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Accepted transactions feed the predictor
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_command(opcode, route_seg, seg_mask, hop_addr, selector_addr, lookup_addr);
	end

	// Strobed results are checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_reply(status, hop_out, multipath_out, selector_out);
	end

	// Present one command and hold it until accepted; start stays high on return
	task automatic send_cmd(input logic [2:0] op, input logic [31:0] seg, input logic [31:0] mask,
			input logic [31:0] hop, input logic [31:0] sel, input logic [31:0] addr);
		start <= 1'b1;
		opcode <= op;
		route_seg <= seg;
		seg_mask <= mask;
		hop_addr <= hop;
		selector_addr <= sel;
		lookup_addr <= addr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every outstanding transaction has returned
	task automatic drain_replies();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One random command; add_pct steers the table toward full or empty
	task automatic send_random(input int add_pct);
		int k;
		int pick;
		logic [2:0]  op;
		logic [31:0] seg;
		logic [31:0] mask;
		logic [31:0] sel;
		logic [31:0] addr;
		k = $urandom_range(0, 7);
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < add_pct)
			op = OP_ADD;
		else if (pick < 15)
			op = OP_DELETE;
		else if (pick < 30)
			op = OP_ATTACH;
		else if (pick < 40)
			op = OP_DETACH;
		else if (pick < 48)
			op = OP_CLEAR_SELECT;
		else if (pick < 97)
			op = OP_LOOKUP;
		else
			op = 3'($urandom_range(6, 7));
		seg = pool_seg[k];
		mask = pool_mask[k];
		if ($urandom_range(0, 9) == 0) begin
			seg = $urandom;
			mask = $urandom;
		end
		sel = ($urandom_range(0, 7) == 0) ? $urandom : sel_pool[$urandom_range(0, 3)];
		if ($urandom_range(0, 9) < 7)
			addr = pool_seg[k] | ($urandom & ~pool_mask[k]);
		else
			addr = $urandom;
		send_cmd(op, seg, mask, $urandom, sel, addr);
	endtask

	initial begin
		int add_pct;
		// route pool: prefix masks, random masks, one segment that rarely matches
		for (int i = 0; i < 8; i++) begin
			pool_mask[i] = (i < 4) ? ~32'h0 << $urandom_range(0, 32) : $urandom;
			pool_seg[i] = $urandom & pool_mask[i];
		end
		pool_seg[7] = $urandom;
		for (int i = 0; i < 4; i++)
			sel_pool[i] = $urandom;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, unused opcodes, default and host routes
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		send_cmd(3'd6, '1, '1, '1, '1, '1);
		send_cmd(3'd7, '1, '1, '1, '1, '1);
		send_cmd(OP_DELETE, '0, '0, '0, '0, '0);
		send_cmd(OP_ADD, '0, '0, 32'h0A00_0001, '1, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		send_cmd(OP_ADD, '1, '1, 32'hC0A8_0101, '1, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, 32'h1234_5678);
		// multipath flag: attach, near miss, clear_select without and with a carrier
		send_cmd(OP_ATTACH, '1, '1, '0, '1, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		send_cmd(OP_ATTACH, '1, 32'hFFFF_FF00, '0, 32'h5, '0);
		send_cmd(OP_CLEAR_SELECT, '0, '0, '0, 32'h5, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		send_cmd(OP_CLEAR_SELECT, '0, '0, '0, '1, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		send_cmd(OP_ATTACH, '1, '1, '0, 32'h0000_00AA, '0);
		send_cmd(OP_DETACH, '1, '1, '0, 32'h1234_0000, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		// duplicate route: attach and delete act on the newest copy
		send_cmd(OP_ADD, '1, '1, 32'h0000_0002, '0, '0);
		send_cmd(OP_ATTACH, '1, '1, '0, 32'h1, '0);
		send_cmd(OP_DELETE, '1, '1, '0, '0, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		send_cmd(OP_DETACH, 32'h0F0F_0F0F, 32'hFF00_FF00, '0, '0, '0);
		send_cmd(OP_DELETE, '0, '0, '0, '0, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '0);
		drain_replies();

		// Random: alternate fill-heavy and drain-heavy phases
		for (int n = 0; n < 1000; n++) begin
			add_pct = ((n / 80) % 2 == 0) ? 70 : 8;
			if (n == 500)
				drain_replies();
			else if (n < 850 && $urandom_range(0, 7) == 0)
				idle_sender($urandom_range(1, 19));
			send_random(add_pct);
		end
		start <= 1'b0;

		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog for a hung handshake
	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
